/* rtl/fpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the fixed-point ALU
// Operation codes, channel payloads and default configuration values.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int FPA_WORD      = 32;
	localparam int FPA_FRAC_BITS = 8;
	// quotient bits resolved by one divider stage
	localparam int FPA_DIV_STEPS = 2;

	typedef enum logic [4:0] {
		OP_ADD      = 5'd0,
		OP_SUB      = 5'd1,
		OP_MUL      = 5'd2,
		OP_DIV      = 5'd3,
		OP_LT       = 5'd4,
		OP_GT       = 5'd5,
		OP_LE       = 5'd6,
		OP_GE       = 5'd7,
		OP_EQ       = 5'd8,
		OP_NE       = 5'd9,
		OP_MIN      = 5'd10,
		OP_MAX      = 5'd11,
		OP_INC      = 5'd12,
		OP_DEC      = 5'd13,
		OP_TO_INT   = 5'd14,
		OP_ABS      = 5'd15,
		OP_FROM_INT = 5'd16
	} op_t;

	typedef struct packed {
		logic [4:0]                 operation;
		logic signed [FPA_WORD-1:0] operand_a;
		logic signed [FPA_WORD-1:0] operand_b;
	} cmd_t;

	typedef struct packed {
		logic signed [FPA_WORD-1:0] result;
		logic                       flag;
		logic                       divide_by_zero;
	} rsp_t;

	// per-item control that rides along the divider stages
	typedef struct packed {
		logic [4:0]          op;
		logic [FPA_WORD-1:0] res;
		logic                flag;
		logic                qneg;
		logic                dbz;
	} side_t;

endpackage

`default_nettype wire

/* rtl/fpa_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_stream_if: valid/ready channel
// One item moves on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface fpa_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/fpa_div_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_div_stage: one register stage of the restoring divider
// Resolves STEPS quotient bits of an unsigned QW-bit by 32-bit division.
// ----------------------------------------------------------------------------
module fpa_div_stage #(
	parameter int QW    = 40,
	parameter int STEPS = 2
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [31:0]   rem_in,
	input  wire logic [QW-1:0] dq_in,
	input  wire logic [31:0]   dsr_in,
	output logic      [31:0]   rem_out,
	output logic      [QW-1:0] dq_out,
	output logic      [31:0]   dsr_out
);
	import fpa_pkg::*;

	logic [31:0]   rem_d;
	logic [QW-1:0] dq_d;
	logic [32:0]   trial;
	logic [32:0]   diff;

	// dq holds the unconsumed dividend bits on top, quotient bits fill from below
	always_comb begin
		rem_d = rem_in;
		dq_d  = dq_in;
		trial = '0;
		diff  = '0;
		for (int i = 0; i < STEPS; i++) begin
			trial = {rem_d, dq_d[QW-1]};
			diff  = trial - {1'b0, dsr_in};
			if (!diff[32]) begin
				rem_d = diff[31:0];
				dq_d  = {dq_d[QW-2:0], 1'b1};
			end else begin
				rem_d = trial[31:0];
				dq_d  = {dq_d[QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= rem_d;
			dq_out  <= dq_d;
			dsr_out <= dsr_in;
		end
	end

endmodule

`default_nettype wire

/* rtl/fixed_point_alu.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu: pipelined signed fixed-point ALU
// Add, subtract, multiply, divide, compare, min/max, increment/decrement, absolute
// value and conversions on 32-bit raw words carrying FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per operation (operation, operand_a, operand_b);
//   rsp returns exactly one item (result, flag, divide_by_zero) per cmd item,
//   in order. Both are valid/ready channels; an item moves when both are high.
//   NS = ceil((32 + FRAC_BITS) / DIV_STEPS) divider stages. Every operation
//   takes the same path so results leave in order.
//   Throughput: one item per cycle while rsp does not stall. The divider
//   keeps this rate: a restoring divider unrolled over NS register stages,
//   DIV_STEPS quotient bits each. The 32x32 multiply sits in the first
//   stage, its rounding in the second.
//   Reset (arst_n low) empties the pipeline; items in flight are dropped and no result is invented.
//   When rsp stalls, each stage holds its item; empty stages upstream of the
//   stall still fill, so cmd keeps accepting until the pipe is full.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
	parameter int FRAC_BITS = fpa_pkg::FPA_FRAC_BITS,
	parameter int DIV_STEPS = fpa_pkg::FPA_DIV_STEPS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	fpa_stream_if.sink    cmd,
	fpa_stream_if.source  rsp
);
	import fpa_pkg::*;

	// quotient width: |a| << FRAC_BITS
	localparam int QW = FPA_WORD + FRAC_BITS;
	// number of divider stages
	localparam int NS = (QW + DIV_STEPS - 1) / DIV_STEPS;

	// stage 0 is the input stage (s1), stages 1..NS are divider stages
	logic                valid_s [0:NS];
	side_t               side_s  [0:NS];
	logic [31:0]         rem_s   [0:NS];
	logic [QW-1:0]       dq_s    [0:NS];
	logic [31:0]         dsr_s   [0:NS];
	logic signed [63:0]  prod_s1;

	// load enable per stage; en[NS+1] is the output register
	logic [NS+1:0]       en;

	logic                rsp_valid_q;
	rsp_t                rsp_data_q;

	// ---------------------------------------------------------------
	// Input decode: everything except multiply rounding and divide
	// ---------------------------------------------------------------
	logic signed [31:0]  a;
	logic signed [31:0]  b;
	logic                a_lt_b;
	logic                b_lt_a;
	logic [31:0]         mag_a;
	logic [31:0]         mag_b;
	logic signed [63:0]  prod_d;
	side_t               side_d;

	assign a      = cmd.payload.operand_a;
	assign b      = cmd.payload.operand_b;
	assign a_lt_b = a < b;
	assign b_lt_a = b < a;
	// two's complement magnitude; most negative gives 2^31 unsigned
	assign mag_a  = a[31] ? (32'd0 - a) : a;
	assign mag_b  = b[31] ? (32'd0 - b) : b;
	assign prod_d = a * b;

	always_comb begin
		side_d      = '0;
		side_d.op   = cmd.payload.operation;
		side_d.qneg = a[31] ^ b[31];
		case (cmd.payload.operation)
			OP_ADD:      side_d.res = a + b;
			OP_SUB:      side_d.res = a - b;
			OP_MUL:      side_d.res = '0;      // filled in stage 1
			OP_DIV:      side_d.dbz = (b == 32'sd0);
			OP_LT:       side_d.flag = a_lt_b;
			OP_GT:       side_d.flag = b_lt_a;
			OP_LE:       side_d.flag = !b_lt_a;
			OP_GE:       side_d.flag = !a_lt_b;
			OP_EQ:       side_d.flag = (a == b);
			OP_NE:       side_d.flag = (a != b);
			OP_MIN:      side_d.res = a_lt_b ? a : b;
			OP_MAX:      side_d.res = b_lt_a ? a : b;
			OP_INC:      side_d.res = a + 32'sd1;
			OP_DEC:      side_d.res = a - 32'sd1;
			OP_TO_INT:   side_d.res = a >>> FRAC_BITS;
			OP_ABS:      side_d.res = a[31] ? (32'd0 - a) : a;
			OP_FROM_INT: side_d.res = a << FRAC_BITS;
			default:     side_d = '0;         // undefined codes give all zero
		endcase
	end

	// ---------------------------------------------------------------
	// Stall handling: a stage loads when empty or when the next one loads
	// ---------------------------------------------------------------
	assign en[NS+1] = !rsp_valid_q || rsp.ready;
	generate
		for (genvar k = NS; k >= 0; k--) begin : g_en
			assign en[k] = !valid_s[k] || en[k+1];
		end
	endgenerate
	assign cmd.ready = en[0];

	// ---------------------------------------------------------------
	// Stage s1: register decoded item, product and divider seed
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en[0]) begin
			valid_s[0] <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s[0] <= side_d;
			prod_s1   <= prod_d;
			rem_s[0]  <= '0;
			dq_s[0]   <= {mag_a, {FRAC_BITS{1'b0}}};
			dsr_s[0]  <= mag_b;
		end
	end

	// multiply: add half an LSB, arithmetic shift, keep low word
	logic signed [63:0]  mul_rnd;
	side_t               side_mul;

	assign mul_rnd = prod_s1 + (64'sd1 <<< (FRAC_BITS - 1));

	always_comb begin
		side_mul = side_s[0];
		if (side_s[0].op == OP_MUL) begin
			side_mul.res = mul_rnd[FRAC_BITS+31:FRAC_BITS];
		end
	end

	// ---------------------------------------------------------------
	// Divider stages; side band and valid travel with the data
	// ---------------------------------------------------------------
	generate
		for (genvar k = 1; k <= NS; k++) begin : g_div
			localparam int LEFT = QW - (k - 1) * DIV_STEPS;
			localparam int SK   = (LEFT < DIV_STEPS) ? LEFT : DIV_STEPS;

			fpa_div_stage #(
				.QW    (QW),
				.STEPS (SK)
			) u_stage (
				.clk     (clk),
				.en      (en[k]),
				.rem_in  (rem_s[k-1]),
				.dq_in   (dq_s[k-1]),
				.dsr_in  (dsr_s[k-1]),
				.rem_out (rem_s[k]),
				.dq_out  (dq_s[k]),
				.dsr_out (dsr_s[k])
			);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (en[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en[k]) begin
					side_s[k] <= (k == 1) ? side_mul : side_s[k-1];
				end
			end
		end
	endgenerate

	// ---------------------------------------------------------------
	// Output register: quotient sign fix and zero-divisor override
	// ---------------------------------------------------------------
	logic [31:0] quo;
	logic [31:0] quo_signed;
	rsp_t        rsp_d;

	assign quo        = dq_s[NS][31:0];
	assign quo_signed = side_s[NS].qneg ? (32'd0 - quo) : quo;

	always_comb begin
		rsp_d.flag           = side_s[NS].flag;
		rsp_d.divide_by_zero = side_s[NS].dbz;
		if (side_s[NS].op == OP_DIV) begin
			rsp_d.result = side_s[NS].dbz ? 32'sd0 : quo_signed;
		end else begin
			rsp_d.result = side_s[NS].res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en[NS+1]) begin
			rsp_valid_q <= valid_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS+1]) begin
			rsp_data_q <= rsp_d;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_data_q;

endmodule

`default_nettype wire

/* dv/fixed_point_alu_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_tb: self-checking bench for the fixed-point ALU
// Feeds directed corner items and random items into the cmd channel and
// predicts each response in the bench. Responses are compared field by field
// in arrival order. Both channels see random idle cycles.
// ----------------------------------------------------------------------------
module fixed_point_alu_tb;
	import fpa_pkg::*;

	localparam int FRAC = FPA_FRAC_BITS;
	// pipe depth in register stages: ceil((32 + FRAC) / DIV_STEPS) + 2
	localparam int PIPE_DEPTH = (FPA_WORD + FRAC + FPA_DIV_STEPS - 1) / FPA_DIV_STEPS + 2;
	localparam int IDLE_PCT = 36;

	// codes outside the defined operation set; the block must answer with zeros
	localparam logic [4:0] OP_UNDEF_LO = 5'd17;
	localparam logic [4:0] OP_UNDEF_HI = 5'd31;

	localparam logic [31:0] WORD_MIN = 32'h8000_0000;
	localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] WORD_ONE = 32'sd1 <<< FRAC;

	logic clk;
	logic arst_n;

	fpa_stream_if #(.payload_t(cmd_t)) cmd_if ();
	fpa_stream_if #(.payload_t(rsp_t)) rsp_if ();

	fixed_point_alu dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	cmd_t pending_q[$];   // items not yet put on the cmd channel
	rsp_t expected_q[$];  // predicted responses, oldest first
	rsp_t arrived_q[$];   // responses taken off rsp, waiting for comparison

	bit steady;           // when set, neither side idles
	int error_count;
	int sent_count;
	int checked_count;
	int dbz_count;
	rsp_t got;
	rsp_t want;

	// 50 MHz bench clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------------
	// Response predictor: one response per item, no state carried over.
	// ------------------------------------------------------------------------
	function automatic rsp_t alu_predict(cmd_t c);
		rsp_t r;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [63:0] prod;
		logic [63:0] mag_a;
		logic [63:0] mag_b;
		logic [63:0] quot;
		a = c.operand_a;
		b = c.operand_b;
		r = '0;
		case (c.operation)
			OP_ADD: r.result = a + b;
			OP_SUB: r.result = a - b;
			OP_MUL: begin
				// full product, round half an LSB up, then drop fraction bits
				prod = longint'(a) * longint'(b);
				prod = prod + (64'sd1 <<< (FRAC - 1));
				prod = prod >>> FRAC;
				r.result = prod[31:0];
			end
			OP_DIV: begin
				if (b == 0) begin
					r.divide_by_zero = 1'b1;
				end else begin
					// magnitudes in 64 bits so the most negative word is exact
					mag_a = a[31] ? (64'h1_0000_0000 - {32'b0, a}) : {32'b0, a};
					mag_b = b[31] ? (64'h1_0000_0000 - {32'b0, b}) : {32'b0, b};
					quot = (mag_a << FRAC) / mag_b;
					if (a[31] ^ b[31])
						quot = -quot;
					r.result = quot[31:0];
				end
			end
			OP_LT: r.flag = (a < b);
			OP_GT: r.flag = (a > b);
			OP_LE: r.flag = (a <= b);
			OP_GE: r.flag = (a >= b);
			OP_EQ: r.flag = (a == b);
			OP_NE: r.flag = (a != b);
			OP_MIN: r.result = (a < b) ? a : b;
			OP_MAX: r.result = (b < a) ? a : b;
			OP_INC: r.result = a + 32'sd1;
			OP_DEC: r.result = a - 32'sd1;
			OP_TO_INT: r.result = a >>> FRAC;
			OP_ABS: r.result = a[31] ? -a : a;
			OP_FROM_INT: r.result = a << FRAC;
			default: r = '0;
		endcase
		return r;
	endfunction

	task automatic add_item(logic [4:0] op, logic [31:0] a, logic [31:0] b);
		cmd_t c;
		c.operation = op;
		c.operand_a = a;
		c.operand_b = b;
		pending_q.push_back(c);
	endtask

	// operand mix: full-range words, small values, corners, and shifted
	// words so that every magnitude shows up
	function automatic logic [31:0] pick_word();
		logic [31:0] w;
		case ($urandom_range(0, 5))
			0, 1: w = $urandom;
			2: w = $urandom_range(0, 2047) - 1024;
			3: begin
				case ($urandom_range(0, 6))
					0: w = WORD_MIN;
					1: w = WORD_MAX;
					2: w = '0;
					3: w = 32'd1;
					4: w = '1;
					5: w = WORD_ONE;
					default: w = -WORD_ONE;
				endcase
			end
			default: begin
				w = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1))
					w = -w;
			end
		endcase
		return w;
	endfunction

	task automatic add_random_items(int count);
		logic [31:0] a;
		logic [31:0] b;
		repeat (count) begin
			a = pick_word();
			// equal operands now and then for the compare and min/max paths
			b = ($urandom_range(0, 9) == 0) ? a : pick_word();
			add_item(5'($urandom_range(OP_ADD, OP_FROM_INT)), a, b);
		end
	endtask

	// wait until every queued item has gone out and every response is back
	task automatic drain();
		while (pending_q.size() != 0 || cmd_if.valid)
			@(negedge clk);
		while (expected_q.size() != 0 || arrived_q.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Driver: presents the next pending item, holds it until accepted, and
	// records the prediction at the edge where cmd takes it.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_if.valid   <= 1'b0;
			cmd_if.payload <= '0;
		end else begin
			if (cmd_if.valid && cmd_if.ready) begin
				expected_q.push_back(alu_predict(cmd_if.payload));
				sent_count++;
			end
			if (!cmd_if.valid || cmd_if.ready) begin
				if (pending_q.size() != 0 &&
				    (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					cmd_if.payload <= pending_q.pop_front();
					cmd_if.valid   <= 1'b1;
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: takes responses off rsp and throttles ready at random.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready)
				arrived_q.push_back(rsp_if.payload);
			rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Comparison runs on the falling edge, after both posedge blocks have
	// updated their queues, so the order of those blocks never matters.
	always @(negedge clk) begin
		while (arrived_q.size() != 0) begin
			got = arrived_q.pop_front();
			if (expected_q.size() == 0) begin
				$error("response with no item outstanding: result %0d flag %0b dbz %0b",
				       got.result, got.flag, got.divide_by_zero);
				error_count++;
			end else begin
				want = expected_q.pop_front();
				checked_count++;
				if (want.divide_by_zero)
					dbz_count++;
				if (got.result !== want.result) begin
					$error("result: expected %0d (0x%08h), got %0d (0x%08h)",
					       want.result, want.result, got.result, got.result);
					error_count++;
				end
				if (got.flag !== want.flag) begin
					$error("flag: expected %0b, got %0b", want.flag, got.flag);
					error_count++;
				end
				if (got.divide_by_zero !== want.divide_by_zero) begin
					$error("divide_by_zero: expected %0b, got %0b",
					       want.divide_by_zero, got.divide_by_zero);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		cmd_if.valid   = 1'b0;
		cmd_if.payload = '0;
		rsp_if.ready   = 1'b0;
		steady         = 1'b0;

		// directed corners: wrap on add/sub/inc/dec, multiply extremes and
		// rounding, zero divisor, overflowing quotients, equal compares,
		// negation of the most negative word, undefined codes
		add_item(OP_ADD, WORD_MAX, 32'd1);
		add_item(OP_SUB, WORD_MIN, 32'd1);
		add_item(OP_MUL, WORD_MIN, WORD_MIN);
		add_item(OP_MUL, WORD_MAX, WORD_MAX);
		add_item(OP_MUL, 32'd1, 32'd128);       // exactly half an LSB, rounds up
		add_item(OP_MUL, '1, 32'd128);          // negative half, rounds toward zero
		add_item(OP_DIV, WORD_ONE, '0);
		add_item(OP_DIV, WORD_MIN, '1);
		add_item(OP_DIV, WORD_MAX, 32'd1);
		add_item(OP_DIV, -WORD_ONE, 32'd3);
		add_item(OP_LT, WORD_MIN, WORD_MAX);
		add_item(OP_GT, WORD_MIN, WORD_MAX);
		add_item(OP_LE, 32'd5, 32'd5);
		add_item(OP_GE, 32'd5, 32'd5);
		add_item(OP_EQ, WORD_MIN, WORD_MIN);
		add_item(OP_NE, WORD_MAX, WORD_MIN);
		add_item(OP_MIN, -WORD_ONE, -WORD_ONE);
		add_item(OP_MAX, WORD_MIN, WORD_MAX);
		add_item(OP_INC, WORD_MAX, '0);
		add_item(OP_DEC, WORD_MIN, '0);
		add_item(OP_TO_INT, -32'sd1, '0);
		add_item(OP_ABS, WORD_MIN, '1);
		add_item(OP_FROM_INT, WORD_MAX, '0);
		add_item(OP_UNDEF_LO, WORD_MAX, WORD_MAX);
		add_item(OP_UNDEF_HI, '1, '1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// first random batch lands behind the directed items with idling on
		@(negedge clk);
		add_random_items(250);
		// hold the sender until the pipe is empty
		drain();

		// no idling on either side: back-to-back items, pipe stays full
		steady = 1'b1;
		add_random_items(100);
		drain();
		steady = 1'b0;

		add_random_items(150);
		drain();

		// let any stray response out of the pipe before judging
		repeat (PIPE_DEPTH + 8) @(negedge clk);

		$display("Checked %0d responses to %0d items over all operations and undefined codes,",
		         checked_count, sent_count);
		$display("including %0d zero divisors, with random stalls and a stall-free stretch.",
		         dbz_count);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// a correct run ends long before this timeout
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

/* fixed_point_alu.f */
rtl/fpa_pkg.sv
rtl/fpa_stream_if.sv
rtl/fpa_div_stage.sv
rtl/fixed_point_alu.sv
dv/fixed_point_alu_tb.sv
